// ----- design/iaat_pkg.sv -----
// Package with the shared types, codes and helpers of the alarm controller.
`timescale 1ns / 1ps
package iaat_pkg;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_PERIMETER = 2'd1,
    CMD_VOLUME    = 2'd2,
    CMD_SIM       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF_AUTO   = 2'd0,
    MODE_OFF_MANUAL = 2'd1,
    MODE_ON_AUTO    = 2'd2,
    MODE_ON_MANUAL  = 2'd3
  } mode_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_DELAY = 1'd1;

  localparam logic [7:0] EXIT_DELAY_RESET  = 8'd60;
  localparam logic [7:0] ENTRY_DELAY_RESET = 8'd30;
  localparam logic [7:0] EXIT_DELAY_MIN    = 8'd4;
  localparam logic [7:0] ENTRY_DELAY_MIN   = 8'd3;

  // Arming countdown step codes; larger values are seconds left.
  localparam logic [7:0] ARM_OFF   = 8'd0;
  localparam logic [7:0] ARM_ARMED = 8'd1;
  localparam logic [7:0] ARM_WAIT  = 8'd2;
  localparam logic [7:0] ARM_CHECK = 8'd3;

  // Trigger countdown step codes; larger values are seconds left.
  localparam logic [7:0] TRIG_IDLE  = 8'd0;
  localparam logic [7:0] TRIG_FIRED = 8'd1;
  localparam logic [7:0] TRIG_DUE   = 8'd2;

  localparam logic [1:0] SHUTTER_NONE      = 2'd0;
  localparam logic [1:0] SHUTTER_DOWN      = 2'd1;
  localparam logic [1:0] SHUTTER_STOP_DOWN = 2'd2;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_OFF  = 2'd1;
  localparam logic [1:0] BEEP_ON   = 2'd3;

  typedef struct packed {
    cmd_t       cmd;
    mode_t      mode;
    logic [7:0] perimeter_tripped;
    logic [7:0] perimeter_open;
    logic [3:0] zone_room;
    logic [7:0] volume_motion;
  } item_t;

  // Current countdowns of one channel, used for the LED decisions.
  typedef struct packed {
    logic [7:0] arm;
    logic [7:0] trig;
  } chan_state_t;

  // Events of one channel for the item being processed.
  typedef struct packed {
    logic accepted;
    logic fire;
    logic not_ready;
    logic armed;
    logic wait_busy;
    logic exit_run;
  } chan_evt_t;

  // Seconds left until a deadline, floored and saturated at 255.
  function automatic logic [7:0] remaining(input logic [31:0] deadline,
                                           input logic [31:0] now,
                                           input logic [7:0]  floor_v);
    logic [31:0] d;
    d = deadline - now;
    if (d[31] || (d <= {24'd0, floor_v})) begin
      return floor_v;
    end else if (d > 32'd255) begin
      return 8'hFF;
    end else begin
      return d[7:0];
    end
  endfunction

endpackage

// ----- design/iaat_in_reg.sv -----
// Input register that holds one accepted item until the processing stage takes it.
`timescale 1ns / 1ps
module iaat_in_reg
  import iaat_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  held_valid,
  output item_t held_item
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- design/iaat_chan.sv -----
// One alarm channel: mode, arming and trigger countdowns, deadline and sensor status.
`timescale 1ns / 1ps
module iaat_chan
  import iaat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        tick,
  input  logic        mode_cmd,
  input  mode_t       mode_in,
  input  logic [31:0] now,
  input  logic [7:0]  exit_delay,
  input  logic [7:0]  entry_delay,
  input  logic [7:0]  sample,
  output chan_state_t state,
  output chan_evt_t   evt
);

  mode_t       mode_r;
  mode_t       mode_next;
  logic [7:0]  arm;
  logic [7:0]  arm_next;
  logic [7:0]  trig;
  logic [7:0]  trig_next;
  logic [31:0] deadline;
  logic [31:0] deadline_next;
  logic [7:0]  status;
  logic [7:0]  status_next;

  assign state.arm  = arm;
  assign state.trig = trig;

  always_comb begin
    mode_next     = mode_r;
    arm_next      = arm;
    trig_next     = trig;
    deadline_next = deadline;
    status_next   = status;
    evt           = '0;
    if (mode_cmd) begin
      // Off auto is honored only from on auto; on auto never overrides on manual.
      if (!((mode_in == MODE_OFF_AUTO) && (mode_r != MODE_ON_AUTO)) &&
          !((mode_in == MODE_ON_AUTO) && (mode_r == MODE_ON_MANUAL))) begin
        evt.accepted = 1'b1;
        mode_next    = mode_in;
        trig_next    = TRIG_IDLE;
        if ((mode_in == MODE_OFF_AUTO) || (mode_in == MODE_OFF_MANUAL)) begin
          arm_next      = ARM_OFF;
          deadline_next = '0;
        end else begin
          arm_next      = exit_delay;
          deadline_next = now + {24'd0, exit_delay};
        end
      end
    end else if (tick) begin
      if (trig == TRIG_IDLE) begin
        status_next = sample;
      end
      if (arm == ARM_ARMED) begin
        if (trig_next == TRIG_DUE) begin
          evt.fire  = 1'b1;
          trig_next = TRIG_FIRED;
        end
        if (trig_next > TRIG_DUE) begin
          trig_next = remaining(deadline, now, TRIG_DUE);
        end
        if ((trig_next == TRIG_IDLE) && (status_next != 8'd0)) begin
          trig_next     = entry_delay;
          deadline_next = now + {24'd0, entry_delay};
        end
      end
      if (arm_next == ARM_WAIT) begin
        if (status_next == 8'd0) begin
          evt.armed = 1'b1;
          arm_next  = ARM_ARMED;
        end else begin
          evt.wait_busy = 1'b1;
        end
      end
      if (arm_next == ARM_CHECK) begin
        evt.not_ready = (status_next != 8'd0);
        arm_next      = ARM_WAIT;
      end
      if (arm_next > ARM_CHECK) begin
        evt.exit_run = 1'b1;
        arm_next     = remaining(deadline, now, ARM_CHECK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r   <= MODE_OFF_AUTO;
      arm      <= ARM_OFF;
      trig     <= TRIG_IDLE;
      deadline <= '0;
      status   <= '0;
    end else if (advance) begin
      mode_r   <= mode_next;
      arm      <= arm_next;
      trig     <= trig_next;
      deadline <= deadline_next;
      status   <= status_next;
    end
  end

endmodule

// ----- design/intrusion_alarm_arm_trigger_fsm.sv -----
// Top level of the two-channel intrusion alarm controller.
`timescale 1ns / 1ps
// Two-channel (perimeter and volume) intrusion alarm controller. Each input
// transfer is either a one-second tick or a mode command for the perimeter
// channel, the volume channel or the presence simulation, and every input
// transfer yields exactly one result transfer. The block takes one item per
// clock cycle; an item is held in the input register and from there goes
// through the processing stage, whose short logic (a 32-bit deadline
// subtract and compare per channel) writes the channel state and the result
// register together. Results wait in the result register while new items
// keep entering, and the input side stalls only when the result register is
// full and not being taken. A tick advances the internal seconds counter
// first and then evaluates both channels against the new time. Arming starts
// the exit delay; when it runs out the channel checks its sensors once,
// warns if they are active, and arms as soon as they are quiet. A detection
// on an armed channel starts the entry delay and then fires the alarm.
// Exit delays below 4 seconds act as 4 and entry delays below 3 act as 3.
// The delay registers are written through the configuration port (index 0
// exit delay, index 1 entry delay), by the user only while no item is in
// flight; the block does not enforce this. ROOM_COUNT sets the room index
// that out-of-range rooms and reset fall back to.
module intrusion_alarm_arm_trigger_fsm
  import iaat_pkg::*;
#(
  parameter int ROOM_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [1:0]           mode,
  input  logic [7:0]           perimeter_tripped,
  input  logic [7:0]           perimeter_open,
  input  logic [3:0]           zone_room,
  input  logic [7:0]           volume_motion,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 green_led,
  output logic                 red_led,
  output logic                 perimeter_fire,
  output logic                 volume_fire,
  output logic                 perimeter_not_ready,
  output logic                 volume_not_ready,
  output logic [1:0]           shutter_cmd,
  output logic                 zones_enable,
  output logic                 channel_reset,
  output logic [1:0]           beep_pulses,
  output logic [3:0]           alarm_room,
  output logic                 simulation_on,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam logic [3:0] ROOM_LAST  = 4'(ROOM_COUNT - 1);
  localparam logic [4:0] ROOM_LIMIT = 5'(ROOM_COUNT);

  // Configuration registers; the port never stalls.
  logic [7:0] exit_delay_seconds;
  logic [7:0] entry_delay_seconds;
  logic [7:0] exit_delay;
  logic [7:0] entry_delay;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      exit_delay_seconds  <= EXIT_DELAY_RESET;
      entry_delay_seconds <= ENTRY_DELAY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EXIT_DELAY:  exit_delay_seconds  <= cfg_data;
        CFG_ENTRY_DELAY: entry_delay_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  assign exit_delay  = (exit_delay_seconds < EXIT_DELAY_MIN) ? EXIT_DELAY_MIN
                                                             : exit_delay_seconds;
  assign entry_delay = (entry_delay_seconds < ENTRY_DELAY_MIN) ? ENTRY_DELAY_MIN
                                                               : entry_delay_seconds;

  // Input register.
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;

  assign in_item.cmd               = cmd_t'(cmd);
  assign in_item.mode              = mode_t'(mode);
  assign in_item.perimeter_tripped = perimeter_tripped;
  assign in_item.perimeter_open    = perimeter_open;
  assign in_item.zone_room         = zone_room;
  assign in_item.volume_motion     = volume_motion;

  // The held item is processed whenever the result register can take its result.
  assign advance = item_valid && (!out_valid || out_ready);

  iaat_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (advance),
    .held_valid (item_valid),
    .held_item  (item)
  );

  // Seconds counter. Mode commands use the current time, ticks the advanced one.
  logic [31:0] seconds_now;
  logic [31:0] now;
  logic        tick;

  assign tick = (item.cmd == CMD_TICK);
  assign now  = tick ? (seconds_now + 32'd1) : seconds_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_now <= '0;
    end else if (advance) begin
      seconds_now <= now;
    end
  end

  // Channels. The perimeter looks at trips while armed and at openings otherwise.
  chan_state_t perim_state;
  chan_state_t vol_state;
  chan_evt_t   perim_evt;
  chan_evt_t   vol_evt;
  logic [7:0]  perim_sample;

  assign perim_sample = (perim_state.arm == ARM_ARMED) ? item.perimeter_tripped
                                                       : item.perimeter_open;

  iaat_chan u_perim (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .tick        (tick),
    .mode_cmd    (item.cmd == CMD_PERIMETER),
    .mode_in     (item.mode),
    .now         (now),
    .exit_delay  (exit_delay),
    .entry_delay (entry_delay),
    .sample      (perim_sample),
    .state       (perim_state),
    .evt         (perim_evt)
  );

  iaat_chan u_vol (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .tick        (tick),
    .mode_cmd    (item.cmd == CMD_VOLUME),
    .mode_in     (item.mode),
    .now         (now),
    .exit_delay  (exit_delay),
    .entry_delay (entry_delay),
    .sample      (item.volume_motion),
    .state       (vol_state),
    .evt         (vol_evt)
  );

  // Room latch, taken with the perimeter status while its trigger is idle.
  logic [3:0] perim_room;
  logic [3:0] perim_room_next;

  assign perim_room_next = ({1'b0, item.zone_room} >= ROOM_LIMIT) ? ROOM_LAST
                                                                  : item.zone_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      perim_room <= ROOM_LAST;
    end else if (advance && tick && (perim_state.trig == TRIG_IDLE)) begin
      perim_room <= perim_room_next;
    end
  end

  // Simulation enable follows the on/off half of the mode code.
  logic sim_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      sim_enable <= 1'b0;
    end else if (advance && (item.cmd == CMD_SIM)) begin
      sim_enable <= (item.mode == MODE_ON_AUTO) || (item.mode == MODE_ON_MANUAL);
    end
  end

  // LEDs. Green shows arming (steady when a channel is armed, blinking while
  // it counts down), red shows triggering the same way. Both alarms fired
  // turns the green LED off. Decisions use the countdowns before this tick.
  logic green_drive;
  logic green_drive_next;
  logic green_mem;
  logic green_mem_next;
  logic red_drive;
  logic red_drive_next;
  logic red_mem;
  logic red_mem_next;

  always_comb begin
    green_drive_next = green_drive;
    green_mem_next   = green_mem;
    red_drive_next   = red_drive;
    red_mem_next     = red_mem;
    if ((perim_state.arm == ARM_ARMED) || (vol_state.arm == ARM_ARMED)) begin
      green_drive_next = 1'b1;
    end else if ((perim_state.arm > ARM_ARMED) || (vol_state.arm > ARM_ARMED)) begin
      green_mem_next   = !green_mem;
      green_drive_next = !green_mem;
    end
    if ((perim_state.arm == ARM_OFF) && (vol_state.arm == ARM_OFF)) begin
      green_drive_next = 1'b0;
    end
    if ((perim_state.trig == TRIG_FIRED) || (vol_state.trig == TRIG_FIRED)) begin
      red_drive_next = 1'b1;
    end else if ((perim_state.trig > TRIG_FIRED) || (vol_state.trig > TRIG_FIRED)) begin
      red_mem_next   = !red_mem;
      red_drive_next = !red_mem;
    end
    if ((perim_state.trig == TRIG_IDLE) && (vol_state.trig == TRIG_IDLE)) begin
      red_drive_next = 1'b0;
    end
    if ((perim_state.trig == TRIG_FIRED) && (vol_state.trig == TRIG_FIRED)) begin
      green_drive_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      green_drive <= 1'b0;
      green_mem   <= 1'b0;
      red_drive   <= 1'b0;
      red_mem     <= 1'b0;
    end else if (advance && tick) begin
      green_drive <= green_drive_next;
      green_mem   <= green_mem_next;
      red_drive   <= red_drive_next;
      red_mem     <= red_mem_next;
    end
  end

  // Per-item pulses and commands.
  logic [1:0] shutter_next;
  logic [1:0] beep_next;
  logic       sim_next;

  always_comb begin
    shutter_next = SHUTTER_NONE;
    if (perim_evt.wait_busy) begin
      shutter_next = SHUTTER_STOP_DOWN;
    end else if (perim_evt.exit_run) begin
      shutter_next = SHUTTER_DOWN;
    end
    beep_next = BEEP_NONE;
    if (perim_evt.accepted && (item.mode == MODE_OFF_MANUAL)) begin
      beep_next = BEEP_OFF;
    end else if (perim_evt.accepted && (item.mode == MODE_ON_MANUAL)) begin
      beep_next = BEEP_ON;
    end
    sim_next = sim_enable;
    if (item.cmd == CMD_SIM) begin
      sim_next = (item.mode == MODE_ON_AUTO) || (item.mode == MODE_ON_MANUAL);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      green_led           <= tick ? green_drive_next : green_drive;
      red_led             <= tick ? red_drive_next : red_drive;
      perimeter_fire      <= perim_evt.fire;
      volume_fire         <= vol_evt.fire;
      perimeter_not_ready <= perim_evt.not_ready;
      volume_not_ready    <= vol_evt.not_ready;
      shutter_cmd         <= shutter_next;
      zones_enable        <= perim_evt.armed;
      channel_reset       <= perim_evt.accepted || vol_evt.accepted;
      beep_pulses         <= beep_next;
      alarm_room          <= (tick && (perim_state.trig == TRIG_IDLE)) ? perim_room_next
                                                                      : perim_room;
      simulation_on       <= sim_next;
    end
  end

endmodule
